// ===== sv/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define BM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("bracket matcher: assertion failed");

// When cond holds, expr holds at the next clock edge.
`define BM_ASSERT_NEXT(lbl, clk, rst_n, cond, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("bracket matcher: assertion failed");

`endif

// ===== sv/bm_pkg.sv =====
`default_nettype none

package bm_pkg;

    // Sizes
    localparam int STACK_DEPTH = 64;
    localparam int MAX_PAIRS   = 4;
    localparam int TABLE_W     = 64;
    localparam int PAIR_CNT_W  = 3;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 64;
    localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PAIR_TABLE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PAIR_COUNT = CFG_IDX_W'(1);

    // Fault codes reported with a verdict
    typedef enum logic [1:0] {
        FAULT_NONE     = 2'd0,
        FAULT_CLOSE    = 2'd1,
        FAULT_UNCLOSED = 2'd2,
        FAULT_OVERFLOW = 2'd3
    } fault_t;

    // One byte handed to the scanning core
    typedef struct packed {
        logic       fire;
        logic [7:0] ch;
        logic       last;
    } step_t;

    // Bracket pair configuration
    typedef struct packed {
        logic [TABLE_W-1:0]    pair_table;
        logic [PAIR_CNT_W-1:0] pair_count;
    } pairs_t;

    // Verdict for one string
    typedef struct packed {
        logic   balanced;
        fault_t fault_kind;
    } verdict_t;

endpackage

`default_nettype wire

// ===== sv/bm_text_if.sv =====
`default_nettype none

// Byte stream channel
interface bm_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

`default_nettype wire

// ===== sv/bm_verdict_if.sv =====
`default_nettype none

// Verdict channel, one request per string
interface bm_verdict_if;
    logic       valid;
    logic       ready;
    logic       balanced;
    logic [1:0] fault_kind;

    modport source (output valid, output balanced, output fault_kind, input ready);
    modport sink   (input valid, input balanced, input fault_kind, output ready);
endinterface

`default_nettype wire

// ===== sv/bm_cfg_if.sv =====
`default_nettype none

// Register write channel
interface bm_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [bm_pkg::CFG_IDX_W-1:0] index;
    logic [bm_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/bm_core.sv =====
`default_nettype none

// Bracket stack and per-byte scan. Top of stack sits in a register; the
// entries below it live in a memory whose registered read always holds the
// entry just under the top, so a pop takes its new top straight from that register.
module bm_core
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire bm_pkg::step_t    step,
    input  wire bm_pkg::pairs_t   pairs,
    output bm_pkg::verdict_t      verdict
);

    logic [7:0]                  mem [bm_pkg::STACK_DEPTH];
    logic [7:0]                  top_reg;
    logic [7:0]                  below_reg;
    logic [bm_pkg::LEVEL_W-1:0]  level_reg;
    logic [bm_pkg::LEVEL_W-1:0]  level_next;
    bm_pkg::fault_t              fault_reg;
    bm_pkg::fault_t              fault_next;
    logic [7:0]                  top_next;

    logic [bm_pkg::PAIR_CNT_W-1:0] n_pairs;
    logic                          is_open;
    logic                          is_close;
    logic [7:0]                    push_val;

    logic [bm_pkg::LEVEL_W-1:0]  level_scan;
    bm_pkg::fault_t              fault_scan;
    logic                        wr_en;
    logic [bm_pkg::LEVEL_W-1:0]  wr_level;
    logic [bm_pkg::LEVEL_W-1:0]  rd_level;

    // Pair classification; higher index wins a shared open byte
    always_comb
    begin
        n_pairs = (pairs.pair_count > bm_pkg::PAIR_CNT_W'(bm_pkg::MAX_PAIRS))
                  ? bm_pkg::PAIR_CNT_W'(bm_pkg::MAX_PAIRS) : pairs.pair_count;
        is_open  = 1'b0;
        is_close = 1'b0;
        push_val = 8'd0;
        for (int i = 0; i < bm_pkg::MAX_PAIRS; i++)
        begin
            if (bm_pkg::PAIR_CNT_W'(i) < n_pairs)
            begin
                if (pairs.pair_table[16*i +: 8] == step.ch)
                begin
                    is_open  = 1'b1;
                    push_val = pairs.pair_table[16*i+8 +: 8];
                end
                if (pairs.pair_table[16*i+8 +: 8] == step.ch)
                    is_close = 1'b1;
            end
        end
    end

    // Push / pop decision
    always_comb
    begin
        level_scan = level_reg;
        fault_scan = fault_reg;
        top_next   = top_reg;
        wr_en      = 1'b0;
        if (step.fire && (fault_reg == bm_pkg::FAULT_NONE))
        begin
            if (is_open)
            begin
                if (level_reg >= bm_pkg::LEVEL_W'(bm_pkg::STACK_DEPTH))
                    fault_scan = bm_pkg::FAULT_OVERFLOW;
                else
                begin
                    wr_en      = (level_reg != '0);
                    top_next   = push_val;
                    level_scan = level_reg + bm_pkg::LEVEL_W'(1);
                end
            end
            else if (is_close)
            begin
                if ((level_reg == '0) || (top_reg != step.ch))
                    fault_scan = bm_pkg::FAULT_CLOSE;
                else
                begin
                    top_next   = below_reg;
                    level_scan = level_reg - bm_pkg::LEVEL_W'(1);
                end
            end
        end

        // end of string clears the stack and fault
        if (step.fire && step.last)
        begin
            level_next = '0;
            fault_next = bm_pkg::FAULT_NONE;
        end
        else
        begin
            level_next = level_scan;
            fault_next = fault_scan;
        end
    end

    // Verdict for the byte in hand, used only on the last byte
    always_comb
    begin
        if (fault_scan != bm_pkg::FAULT_NONE)
            verdict.fault_kind = fault_scan;
        else if (level_scan != '0)
            verdict.fault_kind = bm_pkg::FAULT_UNCLOSED;
        else
            verdict.fault_kind = bm_pkg::FAULT_NONE;
        verdict.balanced = (verdict.fault_kind == bm_pkg::FAULT_NONE);
    end

    assign wr_level = level_reg - bm_pkg::LEVEL_W'(1);
    assign rd_level = level_next - bm_pkg::LEVEL_W'(2);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
            fault_reg <= bm_pkg::FAULT_NONE;
        end
        else
        begin
            level_reg <= level_next;
            fault_reg <= fault_next;
        end
    end

    // Top of stack
    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
    end

    // Memory write: old top moves down on a push
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_level[bm_pkg::ADDR_W-1:0]] <= top_reg;
    end

    // Memory read: entry under the next top, bypassing a same-cycle write
    always_ff @(posedge clk)
    begin
        if (wr_en)
            below_reg <= top_reg;
        else
            below_reg <= mem[rd_level[bm_pkg::ADDR_W-1:0]];
    end

endmodule

`default_nettype wire

// ===== sv/custom_bracket_matcher.sv =====
`default_nettype none

// Channel   Role   Request carries
// -------   ----   -------------------------------------------
// text      sink   ch[7:0], last
// verdict   source balanced, fault_kind[1:0]  (one per string)
// cfg       sink   index, data  (0: pair_table, 1: pair_count)
//
// One byte per cycle unless a final byte waits on a stalled verdict; a verdict is
// offered once its last byte moves from the input register to the verdict register.
// Each byte does at most one top-of-stack compare and at most one push or pop.
// Reset clears stack level, fault and configuration; stack contents are
// not cleared. While a verdict is stalled, non-final bytes keep flowing;
// a second final byte waits in the input register. cfg is always ready.
module custom_bracket_matcher
(
    input wire logic    clk,
    input wire logic    rst_n,
    bm_text_if.sink     text,
    bm_verdict_if.source verdict,
    bm_cfg_if.sink      cfg
);

    logic                           s1_valid_reg;
    logic [7:0]                     s1_ch_reg;
    logic                           s1_last_reg;
    logic                           advance;

    logic                           out_valid_reg;
    logic                           out_bal_reg;
    bm_pkg::fault_t                 out_kind_reg;

    logic [bm_pkg::TABLE_W-1:0]     pair_table_reg;
    logic [bm_pkg::PAIR_CNT_W-1:0]  pair_count_reg;

    bm_pkg::step_t                  step;
    bm_pkg::pairs_t                 pairs;
    bm_pkg::verdict_t               core_verdict;

    // Byte leaves the input register unless it is final and the verdict is stuck
    assign advance    = s1_valid_reg && (!s1_last_reg || !out_valid_reg || verdict.ready);
    assign text.ready = !s1_valid_reg || advance;

    // Configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_table_reg <= '0;
            pair_count_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                bm_pkg::REG_PAIR_TABLE: pair_table_reg <= cfg.data[bm_pkg::TABLE_W-1:0];
                bm_pkg::REG_PAIR_COUNT: pair_count_reg <= cfg.data[bm_pkg::PAIR_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (text.ready)
            s1_valid_reg <= text.valid;
    end

    always_ff @(posedge clk)
    begin
        if (text.valid && text.ready)
        begin
            s1_ch_reg   <= text.ch;
            s1_last_reg <= text.last;
        end
    end

    // Scan core
    assign step.fire        = advance;
    assign step.ch          = s1_ch_reg;
    assign step.last        = s1_last_reg;
    assign pairs.pair_table = pair_table_reg;
    assign pairs.pair_count = pair_count_reg;

    bm_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .pairs   (pairs),
        .verdict (core_verdict)
    );

    // Verdict register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && s1_last_reg)
            out_valid_reg <= 1'b1;
        else if (verdict.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_last_reg)
        begin
            out_bal_reg  <= core_verdict.balanced;
            out_kind_reg <= core_verdict.fault_kind;
        end
    end

    assign verdict.valid      = out_valid_reg;
    assign verdict.balanced   = out_bal_reg;
    assign verdict.fault_kind = out_kind_reg;

endmodule

`default_nettype wire

// ===== sv/bm_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

// Port-level checks on the bracket matcher
module bm_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       text_ready,
    input wire logic       verdict_valid,
    input wire logic       verdict_ready,
    input wire logic       verdict_balanced,
    input wire logic [1:0] verdict_fault_kind
);

    // A stalled verdict stays up
    `BM_ASSERT_NEXT(a_verdict_hold, clk, rst_n, verdict_valid && !verdict_ready, verdict_valid)

    // A stalled verdict keeps its payload
    `BM_ASSERT_NEXT(a_verdict_stable, clk, rst_n, verdict_valid && !verdict_ready, $stable(verdict_balanced) && $stable(verdict_fault_kind))

    // Balanced exactly when no fault is reported
    `BM_ASSERT(a_balanced_kind, clk, rst_n, !verdict_valid || (verdict_balanced == (verdict_fault_kind == bm_pkg::FAULT_NONE)))

    // With no verdict waiting the byte input never stalls
    `BM_ASSERT(a_text_free, clk, rst_n, verdict_valid || text_ready)

endmodule

bind custom_bracket_matcher bm_checker u_bm_checker
(
    .clk                (clk),
    .rst_n              (rst_n),
    .text_ready         (text.ready),
    .verdict_valid      (verdict.valid),
    .verdict_ready      (verdict.ready),
    .verdict_balanced   (verdict.balanced),
    .verdict_fault_kind (verdict.fault_kind)
);

`default_nettype wire
